// ===== sv/cgp_pkg.sv =====
// Shared constants, types and the fraction table builder for the Gaussian profile core.
`timescale 1ns / 1ps

package cgp_pkg;

    localparam int DATA_WIDTH      = 32;
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int TBL_AW          = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int DIV_Q_W         = 35;

    // round(2 * sqrt(ln2 / pi) * 2^32)
    localparam logic [31:0] K_Q32 = 32'd4034852389;

    localparam logic [31:0] AREA_SCALE_RESET = 32'd1073741824;
    localparam logic [23:0] HALF_BOUND_RESET = 24'hFF_FFFF;

    localparam logic [DIV_Q_W-1:0] OUT_MAX = (DATA_WIDTH >= 32) ?
        DIV_Q_W'(64'hFFFF_FFFF) : DIV_Q_W'((64'd1 << DATA_WIDTH) - 64'd1);

    localparam logic [1:0] CFG_AREA_SCALE = 2'd0;
    localparam logic [1:0] CFG_HALF_BOUND = 2'd1;

    typedef logic [31:0] frac_tbl_t [0:EXP_TABLE_DEPTH];

    typedef struct packed {
        logic        crop;
        logic [31:0] fw;
    } side_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        int j;
        v = v_in;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        for (j = 0; j < 32; j++)
        begin
            if (b > v)
            begin
                b = b >> 2;
            end
        end
        for (j = 0; j < 32; j++)
        begin
            if (b != 64'd0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Entry k holds 2^(-k/D) in Q1.31, built from repeated square roots of one half.
    function automatic frac_tbl_t build_frac_tbl();
        frac_tbl_t   t;
        logic [63:0] fac [0:32];
        logic [63:0] s;
        logic [63:0] fr;
        logic [63:0] v;
        int i;
        int k;
        s = 64'd1 << 30;
        fac[0] = s;
        for (i = 1; i <= 32; i++)
        begin
            s = isqrt64(s << 31);
            fac[i] = s;
        end
        for (k = 0; k <= EXP_TABLE_DEPTH; k++)
        begin
            fr = (64'(k) << 32) / EXP_TABLE_DEPTH;
            if (fr >= (64'd1 << 32))
            begin
                v = 64'd1 << 30;
            end
            else
            begin
                v = 64'd1 << 31;
                for (i = 1; i <= 32; i++)
                begin
                    if (fr[32 - i])
                    begin
                        v = (v * fac[i]) >> 31;
                    end
                end
            end
            t[k] = v[31:0];
        end
        return t;
    endfunction

endpackage

// ===== sv/cgp_div.sv =====
// Restoring divider, one quotient bit per pipeline stage.
`timescale 1ns / 1ps

module cgp_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic                         in_crop,
    input  logic [31:0]                  in_hi,
    input  logic [cgp_pkg::DIV_Q_W-1:0]  in_lo,
    input  logic [31:0]                  in_div,
    output logic                         out_valid,
    output logic                         out_crop,
    output logic [cgp_pkg::DIV_Q_W-1:0]  out_quot,
    output logic [31:0]                  out_div
);

    localparam int NS = cgp_pkg::DIV_Q_W;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] c_reg;
    logic [31:0]   rem_reg [NS];
    logic [NS-1:0] lo_reg  [NS];
    logic [31:0]   d_reg   [NS];

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_stage
            logic          v_in;
            logic          c_in;
            logic [31:0]   rem_in;
            logic [NS-1:0] lo_in;
            logic [31:0]   d_in;
            logic [32:0]   trial;
            logic [32:0]   diff;
            logic          ge;
            logic [31:0]   rem_next;
            logic [NS-1:0] lo_next;

            if (k == 0)
            begin : g_first
                assign v_in   = in_valid;
                assign c_in   = in_crop;
                assign rem_in = in_hi;
                assign lo_in  = in_lo;
                assign d_in   = in_div;
            end
            else
            begin : g_rest
                assign v_in   = v_reg[k-1];
                assign c_in   = c_reg[k-1];
                assign rem_in = rem_reg[k-1];
                assign lo_in  = lo_reg[k-1];
                assign d_in   = d_reg[k-1];
            end

            // The numerator bits shift out of the top while quotient bits enter at the bottom.
            assign trial    = {rem_in, lo_in[NS-1]};
            assign diff     = trial - {1'b0, d_in};
            assign ge       = (trial >= {1'b0, d_in});
            assign rem_next = ge ? diff[31:0] : trial[31:0];
            assign lo_next  = {lo_in[NS-2:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    c_reg[k]   <= c_in;
                    rem_reg[k] <= rem_next;
                    lo_reg[k]  <= lo_next;
                    d_reg[k]   <= d_in;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[NS-1];
    assign out_crop  = c_reg[NS-1];
    assign out_quot  = lo_reg[NS-1];
    assign out_div   = d_reg[NS-1];

endmodule

// ===== sv/cgp_exp.sv =====
// Pipeline from the relative position to the scaled power of two 2^(-4*xrel^2).
`timescale 1ns / 1ps

module cgp_exp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  cgp_pkg::side_t        in_side,
    input  logic [23:0]           in_xq,
    output logic                  out_valid,
    output cgp_pkg::side_t        out_side,
    output logic [31:0]           out_g
);

    localparam cgp_pkg::frac_tbl_t FRAC_TBL = cgp_pkg::build_frac_tbl();
    localparam int AW = cgp_pkg::TBL_AW;

    logic [4:0]     v_reg;
    cgp_pkg::side_t side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;

    logic [47:0]    sq_reg;
    logic [31:0]    a2_reg, b2_reg, r2_reg;
    logic [17:0]    n2_reg;
    logic [31:0]    dlt_reg, a3_reg, r3_reg;
    logic           dec3_reg;
    logic [17:0]    n3_reg;
    logic [31:0]    m_reg, a4_reg;
    logic           dec4_reg;
    logic [17:0]    n4_reg;
    logic [31:0]    g_reg;

    logic [49:0]    t;
    logic [31+AW:0] p;
    logic [AW-1:0]  idx;
    logic [AW-1:0]  idx1;
    logic [31:0]    dlt_next;
    logic [63:0]    m_next;
    logic [31:0]    u;
    logic [31:0]    g_next;

    always_comb
    begin
        t        = {sq_reg, 2'b00};
        p        = (32+AW)'(t[31:0]) * (32+AW)'(cgp_pkg::EXP_TABLE_DEPTH);
        idx      = p[32 +: AW];
        idx1     = idx + AW'(1);
        dlt_next = (a2_reg >= b2_reg) ? (a2_reg - b2_reg) : (b2_reg - a2_reg);
        m_next   = 64'(dlt_reg) * 64'(r3_reg);
        u        = dec4_reg ? (a4_reg - m_reg) : (a4_reg + m_reg);
        g_next   = (n4_reg >= 18'd32) ? 32'd0 : (u >> n4_reg[4:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= in_side;
            sq_reg    <= 48'(in_xq) * 48'(in_xq);

            side2_reg <= side1_reg;
            a2_reg    <= FRAC_TBL[idx];
            b2_reg    <= FRAC_TBL[idx1];
            r2_reg    <= p[31:0];
            n2_reg    <= t[49:32];

            side3_reg <= side2_reg;
            dlt_reg   <= dlt_next;
            a3_reg    <= a2_reg;
            r3_reg    <= r2_reg;
            dec3_reg  <= (a2_reg >= b2_reg);
            n3_reg    <= n2_reg;

            side4_reg <= side3_reg;
            m_reg     <= m_next[63:32];
            a4_reg    <= a3_reg;
            dec4_reg  <= dec3_reg;
            n4_reg    <= n3_reg;

            side5_reg <= side4_reg;
            g_reg     <= g_next;
        end
    end

    assign out_valid = v_reg[4];
    assign out_side  = side5_reg;
    assign out_g     = g_reg;

endmodule

// ===== sv/cropped_gaussian_profile_eval_core.sv =====
// Top level of the cropped, area-normalised Gaussian profile evaluator.
//
// Input words (position, width_fwhm) enter on in_valid while in_stall is low;
// each gives one output word (profile_value, cropped) on out_valid, which the
// receiver holds with out_stall. Words leave in the order they entered.
// Configuration is written on the cfg channel (cfg_ready is always high):
// index 0 is area_scale, index 1 is half_bound_rel; other indexes are ignored.
// Write it only while no word is in flight.
// The pipeline has two front stages for the crop test, a 35-stage divider for
// x/fwhm, five stages for the power of two, one multiplier stage, a second
// 35-stage divider for the division by fwhm and the output register. One word is
// accepted every cycle while in_stall is low. When the receiver stalls, a single
// skid register catches the word leaving the pipeline and in_stall rises the
// next cycle; the whole pipeline then holds until the receiver takes a word.
// Reset clears all valid bits, sets area_scale to 1.0 and half_bound_rel to
// its maximum; the exponent table is constant and needs no fill.
`timescale 1ns / 1ps

module cropped_gaussian_profile_eval_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] position,
    input  logic [31:0] width_fwhm,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] profile_value,
    output logic        cropped,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int QW = cgp_pkg::DIV_Q_W;

    logic [31:0] area_scale_reg;
    logic [23:0] half_bound_reg;
    logic [31:0] amp_reg;
    logic [63:0] amp_prod;

    logic        en;

    logic        s1_valid_reg;
    logic [31:0] s1_ax_reg;
    logic [31:0] s1_fw_reg;
    logic [55:0] s1_prod_reg;
    logic [31:0] ax_next;

    logic        s2_valid_reg;
    logic        s2_crop_reg;
    logic [47:0] s2_num_reg;
    logic [31:0] s2_fw_reg;

    logic          d1_valid;
    logic          d1_crop;
    logic [QW-1:0] d1_quot;
    logic [31:0]   d1_div;
    cgp_pkg::side_t d1_side;

    logic           e_valid;
    cgp_pkg::side_t e_side;
    logic [31:0]    e_g;

    logic           m_valid_reg;
    cgp_pkg::side_t m_side_reg;
    logic [63:0]    m_prod_reg;

    logic          d2_valid;
    logic          d2_crop;
    logic [QW-1:0] d2_quot;
    logic [31:0]   d2_div;
    logic [31:0]   tail_value;

    logic        out_valid_reg;
    logic [31:0] out_value_reg;
    logic        out_crop_reg;
    logic        skid_valid_reg;
    logic [31:0] skid_value_reg;
    logic        skid_crop_reg;

    assign cfg_ready = 1'b1;
    assign en        = !skid_valid_reg;
    assign in_stall  = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_scale_reg <= cgp_pkg::AREA_SCALE_RESET;
            half_bound_reg <= cgp_pkg::HALF_BOUND_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cgp_pkg::CFG_AREA_SCALE: area_scale_reg <= cfg_data;
                cgp_pkg::CFG_HALF_BOUND: half_bound_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // The amplitude only follows the register, so it settles while the block is idle.
    assign amp_prod = 64'(cgp_pkg::K_Q32) * 64'(area_scale_reg);

    always_ff @(posedge clk)
    begin
        amp_reg <= amp_prod[63:32];
    end

    assign ax_next = position[31] ? (32'd0 - position) : position;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            m_valid_reg  <= e_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ax_reg   <= ax_next;
            s1_fw_reg   <= width_fwhm;
            s1_prod_reg <= 56'(half_bound_reg) * 56'(width_fwhm);

            s2_crop_reg <= (s1_fw_reg == 32'd0) ||
                           (56'({s1_ax_reg, 16'd0}) >= s1_prod_reg);
            s2_num_reg  <= {s1_ax_reg[31:0], 16'd0};
            s2_fw_reg   <= s1_fw_reg;

            m_side_reg  <= e_side;
            m_prod_reg  <= 64'(amp_reg) * 64'(e_g);
        end
    end

    // Below the crop bound the quotient fits 24 bits, so the top numerator bits stay under fwhm.
    cgp_div u_div_rel (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .in_crop   (s2_crop_reg),
        .in_hi     ({19'd0, s2_num_reg[47:QW]}),
        .in_lo     (s2_num_reg[QW-1:0]),
        .in_div    (s2_fw_reg),
        .out_valid (d1_valid),
        .out_crop  (d1_crop),
        .out_quot  (d1_quot),
        .out_div   (d1_div)
    );

    assign d1_side.crop = d1_crop;
    assign d1_side.fw   = d1_div;

    cgp_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d1_valid),
        .in_side   (d1_side),
        .in_xq     (d1_quot[23:0]),
        .out_valid (e_valid),
        .out_side  (e_side),
        .out_g     (e_g)
    );

    cgp_div u_div_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_valid_reg),
        .in_crop   (m_side_reg.crop),
        .in_hi     (32'd0),
        .in_lo     (m_prod_reg[63:29]),
        .in_div    (m_side_reg.fw),
        .out_valid (d2_valid),
        .out_crop  (d2_crop),
        .out_quot  (d2_quot),
        .out_div   (d2_div)
    );

    always_comb
    begin
        if (d2_crop || (d2_div == 32'd0))
        begin
            tail_value = 32'd0;
        end
        else if (d2_quot > cgp_pkg::OUT_MAX)
        begin
            tail_value = cgp_pkg::OUT_MAX[31:0];
        end
        else
        begin
            tail_value = d2_quot[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg  <= skid_valid_reg || (en && d2_valid);
            skid_valid_reg <= 1'b0;
        end
        else if (en && d2_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_value_reg <= skid_value_reg;
                out_crop_reg  <= skid_crop_reg;
            end
            else
            begin
                out_value_reg <= tail_value;
                out_crop_reg  <= d2_crop;
            end
        end
        else if (en && d2_valid)
        begin
            skid_value_reg <= tail_value;
            skid_crop_reg  <= d2_crop;
        end
    end

    assign out_valid     = out_valid_reg;
    assign profile_value = out_value_reg;
    assign cropped       = out_crop_reg;

endmodule

// ===== sv/cgp_checker.sv =====
// Port-level checks on the Gaussian profile core, bound to the top level.
`timescale 1ns / 1ps

module cgp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] profile_value,
    input logic        cropped
);

    // A stalled output word stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(profile_value) && $stable(cropped))
        else $error("output word changed while stalled");

    // A cropped word always carries a zero value.
    a_crop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cropped |-> profile_value == 32'd0)
        else $error("cropped word with nonzero value");

    // The input side only stalls after the output side was stalled with a word.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall without an output stall");

    // Once the receiver stops stalling, the input side opens the next cycle.
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |=> !in_stall)
        else $error("input still stalled after the output drained");

endmodule

bind cropped_gaussian_profile_eval_core cgp_checker u_cgp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .profile_value (profile_value),
    .cropped       (cropped)
);
